FILE: design/mmdf_pkg.sv
// Package for the moving mean difference filter.
// Holds the sequencer state type, the ring port control struct and fixed field widths.
// No dependencies.
`default_nettype none

package mmdf_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned RESULT_W = 17;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_START,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} ring_ctl_t;

endpackage

`default_nettype wire

FILE: design/mmdf_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on mmdf_pkg for field widths.
`default_nettype none

interface mmdf_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mmdf_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface mmdf_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mmdf_pkg::RESULT_W-1:0]  mean_minus_sample;

	modport source (output valid, output mean_minus_sample, input ready);
	modport sink   (input valid, input mean_minus_sample, output ready);
endinterface

`default_nettype wire

FILE: design/mmdf_ring.sv
// Sample ring storage: one write port, one read port with registered read data.
// Depends on mmdf_pkg (ring_ctl_t, SAMPLE_W).
`default_nettype none

module mmdf_ring #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  wire logic                                 clk,
	input  wire mmdf_pkg::ring_ctl_t                  ctl,
	input  wire logic [AW-1:0]                        wr_addr,
	input  wire logic signed [mmdf_pkg::SAMPLE_W-1:0] wr_data,
	input  wire logic [AW-1:0]                        rd_addr,
	output logic signed [mmdf_pkg::SAMPLE_W-1:0]      rd_data_q
);

	logic signed [mmdf_pkg::SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: design/mmdf_div.sv
// Bit-serial restoring divider: unsigned dividend by unsigned divisor, one quotient bit
// per cycle. Standalone, no package dependency.
`default_nettype none

module mmdf_div #(
	parameter int unsigned DVD_W = 21,
	parameter int unsigned DSR_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DSR_W-1:0] divisor,
	output logic                  done_q,
	output logic [DVD_W-1:0]      quotient
);

	localparam int unsigned IT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

	logic             busy_q;
	logic [IT_W-1:0]  it_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             fits;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				if (it_q == IT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				it_q <= it_q + 1'b1;
			end
		end
	end

	// quotient bits enter at the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
		end
	end

	assign quotient = dvd_q;

endmodule

`default_nettype wire

FILE: design/moving_mean_difference_filter.sv
// Moving mean difference filter, top level: sequencer, running sum and output register.
// Depends on mmdf_pkg, mmdf_if, mmdf_ring and mmdf_div.
//
//  channel | dir | payload                      | transaction when
//  --------+-----+------------------------------+----------------------------
//  smp     | in  | sample            s16        | smp.valid && smp.ready
//  res     | out | mean_minus_sample s17        | res.valid && res.ready
//
// Sequencing: after acceptance a sample passes through READ, START, DIV and FIN
// before smp.ready returns; in DIV the serial divider makes one quotient bit per
// cycle over the SUM_W-bit sum.
// smp.ready is high only while the sequencer is idle.
// The result sits in an output register, so a stalled res does not hold off the
// next sample; only loading a new result waits for the register to empty.
// Reset: asynchronous, active low; clears sequencer, pointer, fill count, sum and output valid.
// The ring itself is not cleared: a slot not yet written is read only while the
// fill count is below WINDOW_LEN, and then its value is taken as zero.
`default_nettype none

module moving_mean_difference_filter #(
	parameter int unsigned WINDOW_LEN = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mmdf_in_if.sink    smp,
	mmdf_out_if.source res
);

	localparam int unsigned PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);
	localparam int unsigned SUM_W = mmdf_pkg::SAMPLE_W + PTR_W + 1;
	localparam int unsigned SW    = mmdf_pkg::SAMPLE_W;
	localparam int unsigned RW    = mmdf_pkg::RESULT_W;

	mmdf_pkg::state_t    state_q, state_d;
	mmdf_pkg::ring_ctl_t ring_ctl;

	logic                 accept;
	logic                 div_start;
	logic                 out_load;

	logic signed [SW-1:0]    sample_q;
	logic [PTR_W-1:0]        ptr_q;
	logic [CNT_W-1:0]        fill_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    neg_q;
	logic signed [SW-1:0]    old_rd;
	logic signed [SW-1:0]    old_val;
	logic                    full;

	logic [SUM_W-1:0]        sum_mag;
	logic                    div_done;
	logic [SUM_W-1:0]        quot;

	logic signed [RW:0]      mean;
	logic signed [RW:0]      diff;

	logic                    out_valid_q;
	logic signed [RW-1:0]    out_q;

	assign accept = smp.valid && smp.ready;
	assign full   = (fill_q == CNT_W'(WINDOW_LEN));

	// A slot is read before the window has filled only when it was never written.
	assign old_val = full ? old_rd : '0;

	mmdf_ring #(
		.DEPTH (WINDOW_LEN),
		.AW    (PTR_W)
	) u_ring (
		.clk       (clk),
		.ctl       (ring_ctl),
		.wr_addr   (ptr_q),
		.wr_data   (sample_q),
		.rd_addr   (ptr_q),
		.rd_data_q (old_rd)
	);

	// Magnitude of the sum; its most negative value never occurs, so it fits unsigned.
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	mmdf_div #(
		.DVD_W (SUM_W),
		.DSR_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_mag),
		.divisor  (fill_q),
		.done_q   (div_done),
		.quotient (quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mmdf_pkg::ST_IDLE: begin
				if (smp.valid) begin
					state_d = mmdf_pkg::ST_READ;
				end
			end
			mmdf_pkg::ST_READ:  state_d = mmdf_pkg::ST_START;
			mmdf_pkg::ST_START: state_d = mmdf_pkg::ST_DIV;
			mmdf_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = mmdf_pkg::ST_FIN;
				end
			end
			mmdf_pkg::ST_FIN: begin
				if (!out_valid_q || res.ready) begin
					state_d = mmdf_pkg::ST_IDLE;
				end
			end
			default: state_d = mmdf_pkg::ST_IDLE;
		endcase
	end

	// state decode
	always_comb begin
		smp.ready      = 1'b0;
		ring_ctl.rd_en = 1'b0;
		ring_ctl.wr_en = 1'b0;
		div_start      = 1'b0;
		out_load       = 1'b0;
		case (state_q)
			mmdf_pkg::ST_IDLE: begin
				smp.ready      = 1'b1;
				ring_ctl.rd_en = smp.valid;
			end
			mmdf_pkg::ST_READ:  ring_ctl.wr_en = 1'b1;
			mmdf_pkg::ST_START: div_start = 1'b1;
			mmdf_pkg::ST_DIV:   ;
			mmdf_pkg::ST_FIN:   out_load = !out_valid_q || res.ready;
			default:            ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmdf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window state: oldest sample leaves the sum, the new one enters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (ring_ctl.wr_en) begin
			sum_q <= sum_q - SUM_W'(old_val) + SUM_W'(sample_q);
			if (ptr_q == PTR_W'(WINDOW_LEN - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= smp.sample;
		end
		if (div_start) begin
			neg_q <= sum_q[SUM_W-1];
		end
	end

	// truncation toward zero: divide magnitudes, then restore the sign
	assign mean = neg_q ? -(RW+1)'(quot) : (RW+1)'(quot);
	assign diff = mean - (RW+1)'(sample_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= diff[RW-1:0];
		end
	end

	assign res.valid             = out_valid_q;
	assign res.mean_minus_sample = out_q;

endmodule

`default_nettype wire

FILE: design/mmdf_chk.sv
// Port-level checker for the moving mean difference filter, bound to the top level.
// Depends on mmdf_pkg for field widths.
`default_nettype none

module mmdf_chk (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 smp_valid,
	input wire logic                                 smp_ready,
	input wire logic                                 res_valid,
	input wire logic                                 res_ready,
	input wire logic signed [mmdf_pkg::RESULT_W-1:0] res_data
);

	// after a sample transaction, input ready stays low while the block is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready |=> !smp_ready ##1 !smp_ready ##1 !smp_ready)
		else $error("input ready too soon after a sample transaction");

	// a new result appears only as the block returns to idle
	a_result_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> smp_ready)
		else $error("result shown while block still busy");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("result changed while stalled");

endmodule

bind moving_mean_difference_filter mmdf_chk u_mmdf_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.smp_valid (smp.valid),
	.smp_ready (smp.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.mean_minus_sample)
);

`default_nettype wire
